/* rtl/core/pca_pkg.sv */
package pca_pkg;

    // Request kinds carried by req_type.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_POP,
        S_FREE_OWN,
        S_FREE_PUSH,
        S_FINISH
    } pca_state_t;

endpackage

/* rtl/core/per_cpu_page_allocator.sv */
// Per-CPU page allocator with stealing.
// Input channel (in_valid/in_stall) carries one request word: req_type selects
// allocate or free, cpu_id names the requester of an allocation and page_index
// the page to free. Output channel (out_valid/out_stall) returns one word per
// request: page_out and status (ok, nothing free anywhere, index or CPU out of range).
// Requests are handled one at a time. A local allocation passes the check, pop
// and finish states before the result register is loaded, a free the owner
// lookup, push and finish states, a range error only the finish state. An
// allocation whose own list is empty walks the list heads one CPU per cycle;
// this scan and the registered link memory read set the latency. The next word
// is accepted in the cycle after the result is loaded, even while that result
// is still stalled downstream. After reset the block writes the initial link
// chains and owner tags into its memories, one page per cycle; in_stall stays
// high during that sweep. When the receiver stalls, the result word holds
// steady and a finished request waits until the output register frees up.
module per_cpu_page_allocator
    import pca_pkg::*;
#(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [2:0] cpu_id,
    input  logic [9:0] page_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] page_out,
    output logic [1:0] status
);

    // Widths: page address, link (address plus null code), CPU number.
    localparam int AW = $clog2(NUM_PAGES);
    localparam int PW = $clog2(NUM_PAGES + 1);
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int XW = (PW > 10) ? PW : 10;
    localparam int YW = (CW + 1 > 4) ? CW + 1 : 4;
    // Pages per CPU block at reset; the last CPU also takes the remainder.
    localparam int BLK = (NUM_PAGES / NUM_CPUS > 0) ? NUM_PAGES / NUM_CPUS : 1;
    localparam int BW  = (BLK > 1) ? $clog2(BLK) : 1;

    localparam logic [PW-1:0] NULL_LINK = PW'(NUM_PAGES);
    localparam logic [CW-1:0] LAST_CPU  = CW'(NUM_CPUS - 1);
    localparam logic [AW-1:0] LAST_PAGE = AW'(NUM_PAGES - 1);

    // Top page of a CPU's reset block, or the null link if it owns none.
    function automatic logic [PW-1:0] head_init(input int c);
        int lo;
        int hi;
        begin
            lo = c * BLK;
            if (c == NUM_CPUS - 1)
            begin
                hi = NUM_PAGES - 1;
            end
            else
            begin
                hi = (c + 1) * BLK - 1;
            end
            if (lo >= NUM_PAGES)
            begin
                return NULL_LINK;
            end
            return PW'(hi);
        end
    endfunction

    // Memories: next link per page and owner CPU per page.
    logic [PW-1:0] link_mem  [NUM_PAGES];
    logic [CW-1:0] owner_mem [NUM_PAGES];
    logic [PW-1:0] link_rd;
    logic [CW-1:0] owner_rd;

    logic          link_we;
    logic [AW-1:0] link_waddr;
    logic [PW-1:0] link_wdata;
    logic [AW-1:0] link_raddr;
    logic          owner_we;
    logic [AW-1:0] owner_waddr;
    logic [CW-1:0] owner_wdata;
    logic [AW-1:0] owner_raddr;

    // List heads, one per CPU, read and written at head_idx_reg only.
    logic [PW-1:0] head_reg [NUM_CPUS];
    logic          head_we;
    logic [PW-1:0] head_wdata;
    logic [PW-1:0] head_rd;

    pca_state_t    state_reg, state_next;
    logic [CW-1:0] head_idx_reg, head_idx_next;
    logic          scan_reg, scan_next;
    logic          req_reg, req_next;
    logic [CW-1:0] cpu_reg, cpu_next;
    logic [AW-1:0] page_reg, page_next;
    logic [1:0]    res_stat_reg, res_stat_next;

    logic [AW-1:0] init_cnt_reg, init_cnt_next;
    logic [CW-1:0] init_own_reg, init_own_next;
    logic [BW-1:0] blk_cnt_reg, blk_cnt_next;
    logic          first_reg, first_next;

    logic          out_valid_reg, out_valid_next;
    logic [9:0]    page_out_reg, page_out_next;
    logic [1:0]    status_reg, status_next;

    logic [XW-1:0] idx_wide;
    logic [YW-1:0] cpu_wide;
    logic [XW-1:0] res_wide;
    logic [CW-1:0] own_clamped;

    assign head_rd     = head_reg[head_idx_reg];
    assign idx_wide    = XW'(page_index);
    assign cpu_wide    = YW'(cpu_id);
    assign res_wide    = XW'(page_reg);
    assign own_clamped = (owner_rd > LAST_CPU) ? LAST_CPU : owner_rd;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign page_out  = page_out_reg;
    assign status    = status_reg;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (owner_we)
        begin
            owner_mem[owner_waddr] <= owner_wdata;
        end
        link_rd  <= link_mem[link_raddr];
        owner_rd <= owner_mem[owner_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_reg[c] <= head_init(c);
            end
        end
        else if (head_we)
        begin
            head_reg[head_idx_reg] <= head_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            head_idx_reg  <= '0;
            scan_reg      <= 1'b0;
            init_cnt_reg  <= '0;
            init_own_reg  <= '0;
            blk_cnt_reg   <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_idx_reg  <= head_idx_next;
            scan_reg      <= scan_next;
            init_cnt_reg  <= init_cnt_next;
            init_own_reg  <= init_own_next;
            blk_cnt_reg   <= blk_cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        cpu_reg      <= cpu_next;
        page_reg     <= page_next;
        res_stat_reg <= res_stat_next;
        page_out_reg <= page_out_next;
        status_reg   <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_idx_next  = head_idx_reg;
        scan_next      = scan_reg;
        req_next       = req_reg;
        cpu_next       = cpu_reg;
        page_next      = page_reg;
        res_stat_next  = res_stat_reg;
        init_cnt_next  = init_cnt_reg;
        init_own_next  = init_own_reg;
        blk_cnt_next   = blk_cnt_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        page_out_next  = page_out_reg;
        status_next    = status_reg;

        link_we     = 1'b0;
        link_waddr  = page_reg;
        link_wdata  = head_rd;
        link_raddr  = head_rd[AW-1:0];
        owner_we    = 1'b0;
        owner_waddr = page_reg;
        owner_wdata = cpu_reg;
        owner_raddr = idx_wide[AW-1:0];
        head_we     = 1'b0;
        head_wdata  = link_rd;

        // The output word drains independently of the request in flight.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                // Rebuild the reset chains: each page links to the page below
                // it in its own block, and the bottom of a block links to null.
                link_we     = 1'b1;
                link_waddr  = init_cnt_reg;
                link_wdata  = first_reg ? NULL_LINK : (PW'(init_cnt_reg) - PW'(1));
                owner_we    = 1'b1;
                owner_waddr = init_cnt_reg;
                owner_wdata = init_own_reg;
                first_next  = 1'b0;
                if (blk_cnt_reg == BW'(BLK - 1) && init_own_reg != LAST_CPU)
                begin
                    init_own_next = init_own_reg + CW'(1);
                    blk_cnt_next  = '0;
                    first_next    = 1'b1;
                end
                else if (blk_cnt_reg != BW'(BLK - 1))
                begin
                    blk_cnt_next = blk_cnt_reg + BW'(1);
                end
                init_cnt_next = init_cnt_reg + AW'(1);
                if (init_cnt_reg == LAST_PAGE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next      = req_type;
                    cpu_next      = cpu_wide[CW-1:0];
                    page_next     = idx_wide[AW-1:0];
                    head_idx_next = cpu_wide[CW-1:0];
                    scan_next     = 1'b0;
                    res_stat_next = STAT_OK;
                    if (req_type == REQ_ALLOC)
                    begin
                        if (cpu_wide >= YW'(NUM_CPUS))
                        begin
                            res_stat_next = STAT_RANGE;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    else
                    begin
                        if (idx_wide >= XW'(NUM_PAGES))
                        begin
                            res_stat_next = STAT_RANGE;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            // The owner memory is read at page_index this edge.
                            state_next = S_FREE_OWN;
                        end
                    end
                end
            end

            S_CHECK:
            begin
                // Own list first, then every CPU from zero upward. The own
                // list is known empty by then, so revisiting it is harmless.
                if (head_rd != NULL_LINK)
                begin
                    page_next  = head_rd[AW-1:0];
                    state_next = S_POP;
                end
                else if (!scan_reg)
                begin
                    scan_next     = 1'b1;
                    head_idx_next = '0;
                end
                else if (head_idx_reg == LAST_CPU)
                begin
                    res_stat_next = STAT_EMPTY;
                    state_next    = S_FINISH;
                end
                else
                begin
                    head_idx_next = head_idx_reg + CW'(1);
                end
            end

            S_POP:
            begin
                head_we    = 1'b1;
                head_wdata = link_rd;
                if (head_idx_reg != cpu_reg)
                begin
                    owner_we = 1'b1;
                end
                state_next = S_FINISH;
            end

            S_FREE_OWN:
            begin
                head_idx_next = own_clamped;
                state_next    = S_FREE_PUSH;
            end

            S_FREE_PUSH:
            begin
                link_we    = 1'b1;
                link_wdata = head_rd;
                head_we    = 1'b1;
                head_wdata = PW'(page_reg);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_stat_reg;
                    if (req_reg == REQ_ALLOC && res_stat_reg == STAT_OK)
                    begin
                        page_out_next = res_wide[9:0];
                    end
                    else
                    begin
                        page_out_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
